/* rtl/assert_macros.svh */
// Assertion macros used by the converter RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent in this cycle implies consequent in the next cycle.
`define U2A_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the same cycle.
`define U2A_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* rtl/u2a_pkg.sv */
// Package for the unsigned to ASCII digits converter.
// Types, constants and helper functions; depends on nothing.
package u2a_pkg;

    localparam int NUM_CELLS  = 10;
    localparam int VALUE_W    = 32;
    localparam int DIGIT_W    = 4;
    localparam int REM_W      = $clog2(NUM_CELLS + 1);
    localparam int BIT_CNT_W  = $clog2(VALUE_W);

    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_LF   = 8'h0A;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_A    = 8'h41;

    localparam logic CMD_DEC = 1'b0;
    localparam logic CMD_HEX = 1'b1;

    localparam logic [1:0] HW_2 = 2'd0;
    localparam logic [1:0] HW_4 = 2'd1;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_DABBLE,
        CELL_SHIFT
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     serial_bit;
    } cell_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DABBLE,
        ST_EMIT,
        ST_CR,
        ST_LF
    } state_t;

    // Number of nibbles taken in hex mode; the unused code means eight.
    function automatic logic [REM_W-1:0] hex_nibbles(input logic [1:0] hw);
        logic [REM_W-1:0] n;
        case (hw)
            HW_2:    n = REM_W'(2);
            HW_4:    n = REM_W'(4);
            default: n = REM_W'(8);
        endcase
        return n;
    endfunction

    // Nibble that cell idx takes at load time in hex mode. The most
    // significant nibble lands in the top cell of the chain.
    function automatic logic [DIGIT_W-1:0] hex_load_nibble(
        input logic [VALUE_W-1:0] v,
        input logic [1:0]         hw,
        input int                 idx
    );
        int                 pos;
        logic [VALUE_W-1:0] tmp;
        pos = idx - (NUM_CELLS - int'(hex_nibbles(hw)));
        tmp = v >> (DIGIT_W * pos);
        if (pos < 0) begin
            return '0;
        end
        return tmp[DIGIT_W-1:0];
    endfunction

    function automatic logic [7:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
        logic [7:0] c;
        if (d < DIGIT_W'(10)) begin
            c = CHAR_ZERO + 8'(d);
        end
        else begin
            c = CHAR_A + 8'(d) - 8'd10;
        end
        return c;
    endfunction

endpackage

/* rtl/u2a_if.sv */
// Valid/ready channel interfaces for the converter.
// Depends on nothing; used by the top level and the controller.
interface u2a_num_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [31:0] value;
    logic [1:0]  hex_width;
    logic        add_line_end;

    modport source (output valid, cmd, value, hex_width, add_line_end, input ready);
    modport sink   (input valid, cmd, value, hex_width, add_line_end, output ready);
endinterface

interface u2a_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_out;
    logic       last;

    modport source (output valid, char_out, last, input ready);
    modport sink   (input valid, char_out, last, output ready);
endinterface

/* rtl/u2a_cell.sv */
// One BCD digit cell of the conversion chain.
// Depends on u2a_pkg for the cell control struct.
module u2a_cell (
    input  logic                            clk,
    input  u2a_pkg::cell_ctrl_t             ctrl,
    input  logic                            carry_in,
    input  logic [u2a_pkg::DIGIT_W-1:0]     digit_in,
    input  logic [u2a_pkg::DIGIT_W-1:0]     load_digit,
    output logic                            carry_out,
    output logic [u2a_pkg::DIGIT_W-1:0]     digit
);
    import u2a_pkg::*;

    logic [DIGIT_W-1:0] digit_reg;
    logic [DIGIT_W-1:0] digit_next;
    logic [DIGIT_W-1:0] adj;

    // Add three before the shift so the digit never passes nine.
    assign adj       = (digit_reg >= DIGIT_W'(5)) ? digit_reg + DIGIT_W'(3) : digit_reg;
    assign carry_out = adj[DIGIT_W-1];
    assign digit     = digit_reg;

    always_comb
    begin
        case (ctrl.op)
            CELL_LOAD:   digit_next = load_digit;
            CELL_DABBLE: digit_next = {adj[DIGIT_W-2:0], carry_in};
            CELL_SHIFT:  digit_next = digit_in;
            default:     digit_next = digit_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

endmodule

/* rtl/u2a_ctrl.sv */
// Sequencer and output register of the converter.
// Depends on u2a_pkg, u2a_if.sv and assert_macros.svh.
`include "assert_macros.svh"

module u2a_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    u2a_num_if.sink                       number,
    u2a_char_if.source                    chars,
    input  logic [u2a_pkg::DIGIT_W-1:0]   top_digit,
    output u2a_pkg::cell_ctrl_t           cell_ctrl
);
    import u2a_pkg::*;

    state_t               state_reg, state_next;
    logic [VALUE_W-1:0]   value_reg, value_next;
    logic [BIT_CNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic [REM_W-1:0]     rem_reg, rem_next;
    logic                 started_reg, started_next;
    logic                 add_le_reg, add_le_next;
    logic                 out_valid_reg, out_valid_next;
    logic [7:0]           char_reg, char_next;
    logic                 last_reg, last_next;

    logic       accept;
    logic       slot_free;
    logic       keep_digit;
    logic       step;
    logic       emit;
    logic       emit_last;
    logic [7:0] emit_char;

    assign accept     = number.valid && number.ready;
    assign slot_free  = !out_valid_reg || chars.ready;
    assign keep_digit = started_reg || (rem_reg == REM_W'(1)) || (top_digit != '0);
    // A leading zero is dropped without waiting for the output slot.
    assign step       = keep_digit ? slot_free : 1'b1;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (number.valid) begin
                    state_next = (number.cmd == CMD_HEX) ? ST_EMIT : ST_DABBLE;
                end
            ST_DABBLE:
                if (bit_cnt_reg == BIT_CNT_W'(VALUE_W - 1)) begin
                    state_next = ST_EMIT;
                end
            ST_EMIT:
                if (step && (rem_reg == REM_W'(1))) begin
                    state_next = add_le_reg ? ST_CR : ST_IDLE;
                end
            ST_CR:
                if (slot_free) begin
                    state_next = ST_LF;
                end
            ST_LF:
                if (slot_free) begin
                    state_next = ST_IDLE;
                end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        number.ready         = 1'b0;
        cell_ctrl.op         = CELL_HOLD;
        cell_ctrl.serial_bit = value_reg[VALUE_W-1];
        emit                 = 1'b0;
        emit_last            = 1'b0;
        emit_char            = digit_to_ascii(top_digit);
        unique case (state_reg)
            ST_IDLE:
            begin
                number.ready = 1'b1;
                if (number.valid) begin
                    cell_ctrl.op = CELL_LOAD;
                end
            end
            ST_DABBLE:
                cell_ctrl.op = CELL_DABBLE;
            ST_EMIT:
            begin
                if (step) begin
                    cell_ctrl.op = CELL_SHIFT;
                end
                emit      = keep_digit && slot_free;
                emit_last = (rem_reg == REM_W'(1)) && !add_le_reg;
            end
            ST_CR:
            begin
                emit      = slot_free;
                emit_char = CHAR_CR;
            end
            ST_LF:
            begin
                emit      = slot_free;
                emit_char = CHAR_LF;
                emit_last = 1'b1;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        value_next     = value_reg;
        bit_cnt_next   = bit_cnt_reg;
        rem_next       = rem_reg;
        started_next   = started_reg;
        add_le_next    = add_le_reg;
        out_valid_next = out_valid_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        if (accept) begin
            value_next   = number.value;
            bit_cnt_next = '0;
            started_next = 1'b0;
            add_le_next  = number.add_line_end;
            rem_next     = (number.cmd == CMD_HEX) ? hex_nibbles(number.hex_width)
                                                   : REM_W'(NUM_CELLS);
        end
        if (state_reg == ST_DABBLE) begin
            value_next   = {value_reg[VALUE_W-2:0], 1'b0};
            bit_cnt_next = bit_cnt_reg + BIT_CNT_W'(1);
        end
        if ((state_reg == ST_EMIT) && step) begin
            rem_next = rem_reg - REM_W'(1);
        end
        if ((state_reg == ST_EMIT) && emit) begin
            started_next = 1'b1;
        end
        if (emit) begin
            out_valid_next = 1'b1;
            char_next      = emit_char;
            last_next      = emit_last;
        end
        else if (chars.ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            bit_cnt_reg   <= '0;
            rem_reg       <= '0;
            started_reg   <= 1'b0;
            add_le_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else begin
            state_reg     <= state_next;
            bit_cnt_reg   <= bit_cnt_next;
            rem_reg       <= rem_next;
            started_reg   <= started_next;
            add_le_reg    <= add_le_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        char_reg  <= char_next;
        last_reg  <= last_next;
    end

    assign chars.valid    = out_valid_reg;
    assign chars.char_out = char_reg;
    assign chars.last     = last_reg;

    `U2A_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, !number.ready, "ready held after accept")
    `U2A_ASSERT_NEXT(a_dabble_done, clk, rst_n,
        (state_reg == ST_DABBLE) && (bit_cnt_reg == BIT_CNT_W'(VALUE_W - 1)),
        (state_reg == ST_EMIT) && (rem_reg == REM_W'(NUM_CELLS)), "bad end of dabble")
    `U2A_ASSERT_NEXT(a_last_idle, clk, rst_n, emit && emit_last,
        (state_reg == ST_IDLE) && chars.valid && chars.last, "last item not final")
    `U2A_ASSERT_SAME(a_emit_slot, clk, rst_n, emit, slot_free, "output overwritten")

endmodule

/* rtl/unsigned_to_ascii_digits_unit.sv */
// Top level of the unsigned to ASCII digits converter.
// Depends on u2a_pkg, u2a_if.sv, u2a_cell and u2a_ctrl.
//
//   Channel   Role    Payload
//   number    sink    cmd, value[31:0], hex_width[1:0], add_line_end
//   chars     source  char_out[7:0], last
//
// A number is taken only while the converter is idle. Decimal clears the chain
// and double-dabbles all 32 value bits into the ten-cell BCD chain; hex loads
// its nibbles straight into the cells. Each digit position is then taken from
// the top of the chain (ten for decimal, 2, 4 or 8 for hex), then CR and LF if
// add_line_end is set. Leading zeros are dropped without waiting on chars.ready;
// a shown character waits for a free output register. Reset (rst_n, async
// low) clears the sequencer and the output valid; the cells need no reset.
module unsigned_to_ascii_digits_unit (
    input  logic         clk,
    input  logic         rst_n,
    u2a_num_if.sink      number,
    u2a_char_if.source   chars
);
    import u2a_pkg::*;

    cell_ctrl_t         cell_ctrl;
    logic               carry_w [NUM_CELLS];
    logic [DIGIT_W-1:0] digit_w [NUM_CELLS];

    // The chain: cell 0 takes the serial value bit during double dabble, and
    // during emission every cell hands its digit one place toward the top.
    genvar i;
    generate
        for (i = 0; i < NUM_CELLS; i++) begin : g_cell
            logic               cin;
            logic [DIGIT_W-1:0] din;
            logic [DIGIT_W-1:0] ld;

            if (i == 0) begin : g_first
                assign cin = cell_ctrl.serial_bit;
                assign din = '0;
            end
            else begin : g_rest
                assign cin = carry_w[i-1];
                assign din = digit_w[i-1];
            end

            // Decimal starts from an all-zero chain; hex places its nibbles
            // directly, the most significant one in the top cell.
            assign ld = (number.cmd == CMD_HEX)
                      ? hex_load_nibble(number.value, number.hex_width, i) : '0;

            u2a_cell u_cell (
                .clk        (clk),
                .ctrl       (cell_ctrl),
                .carry_in   (cin),
                .digit_in   (din),
                .load_digit (ld),
                .carry_out  (carry_w[i]),
                .digit      (digit_w[i])
            );
        end
    endgenerate

    u2a_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .number    (number),
        .chars     (chars),
        .top_digit (digit_w[NUM_CELLS-1]),
        .cell_ctrl (cell_ctrl)
    );

endmodule

/* tb/sv/tb_unsigned_to_ascii_digits_unit.sv */
// Self-checking testbench for unsigned_to_ascii_digits_unit: numbers go in on a
// valid/ready channel, ASCII characters are checked against an in-bench predictor.
// Depends on u2a_pkg, the channel interfaces in u2a_if.sv and the converter RTL.
module tb_unsigned_to_ascii_digits_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import u2a_pkg::*;

    // Hex width codes that the package does not name. The unused code must
    // behave like the eight-nibble code.
    localparam logic [1:0] HEX_W8     = 2'd2;
    localparam logic [1:0] HEX_UNUSED = 2'd3;

    // Generous cycle budget. A decimal number runs double dabble inside the
    // converter, and up to twelve characters may each wait on a stalled sink.
    localparam int CYCLE_LIMIT = 400000;

    // Cycles allowed after the last character, so that a stray character
    // still inside the converter has time to show up.
    localparam int DRAIN_CYCLES = 64;

    typedef struct packed {
        logic        cmd;
        logic [31:0] value;
        logic [1:0]  hex_width;
        logic        add_line_end;
    } number_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } ascii_char_t;

    logic clk;
    logic rst_n;

    u2a_num_if  number_ch ();
    u2a_char_if chars_ch ();

    unsigned_to_ascii_digits_unit DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .number (number_ch),
        .chars  (chars_ch)
    );

    // Numbers waiting to be driven, and the characters that accepted numbers
    // are still owed.
    number_t     numbers_to_send[$];
    ascii_char_t expected_chars[$];
    number_t     outgoing;

    int   items_queued;
    int   items_accepted;
    int   mismatch_count;
    int   cycle_count;
    int   send_idle_pct;
    int   recv_stall_pct;
    logic number_taken;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // One line per mismatch, and a count that decides the final verdict.
    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Works out the characters of one accepted number and appends them to the
    // store of expected characters, with the last flag on the final one.
    function automatic void predict_chars(input number_t n);
        logic [7:0]  text[$];
        logic [31:0] v;
        logic [3:0]  nib;
        int          nibbles;
        bit          started;
        v = n.value;
        started = 1'b0;
        if (n.cmd == CMD_DEC)
        begin
            // Peel off decimal digits from the low end; zero still shows as "0".
            if (v == 32'd0)
            begin
                text.push_back(CHAR_ZERO);
            end
            while (v != 32'd0)
            begin
                text.push_front(CHAR_ZERO + 8'(v % 32'd10));
                v = v / 32'd10;
            end
        end
        else
        begin
            case (n.hex_width)
                HW_2:       nibbles = 2;
                HW_4:       nibbles = 4;
                HEX_W8:     nibbles = 8;
                HEX_UNUSED: nibbles = 8;
                default:    nibbles = 8;
            endcase
            // Nibbles above the chosen width never show, and leading zero
            // nibbles are dropped until the first nonzero one.
            for (int i = nibbles - 1; i >= 0; i--)
            begin
                nib = v[4 * i +: 4];
                if (nib != 4'd0)
                begin
                    started = 1'b1;
                end
                if (started)
                begin
                    text.push_back((nib < 4'd10) ? CHAR_ZERO + 8'(nib)
                                                 : CHAR_A + 8'(nib) - 8'd10);
                end
            end
            if (text.size() == 0)
            begin
                text.push_back(CHAR_ZERO);
            end
        end
        if (n.add_line_end)
        begin
            text.push_back(CHAR_CR);
            text.push_back(CHAR_LF);
        end
        foreach (text[k])
        begin
            expected_chars.push_back('{ch: text[k], last: (k == text.size() - 1)});
        end
    endfunction

    function automatic number_t make_number(input logic cmd, input logic [31:0] value,
                                            input logic [1:0] hw, input logic le);
        number_t n;
        n.cmd          = cmd;
        n.value        = value;
        n.hex_width    = hw;
        n.add_line_end = le;
        return n;
    endfunction

    // Random number with its value drawn from a mix of shapes: full-range values,
    // small values, values around powers of ten, values with many leading zero
    // nibbles, values of random bit length, and the all-ones and zero extremes.
    function automatic number_t random_number();
        number_t     n;
        logic [31:0] pow10;
        int          exp10;
        n.cmd          = 1'($urandom_range(0, 1));
        n.hex_width    = 2'($urandom_range(0, 3));
        n.add_line_end = 1'($urandom_range(0, 1));
        pow10 = 32'd1;
        case ($urandom_range(0, 9)) inside
            [0:3]:      n.value = $urandom();
            4:          n.value = $urandom_range(0, 15);
            5:          n.value = $urandom_range(0, 999);
            6:
            begin
                exp10 = $urandom_range(0, 9);
                for (int k = 0; k < exp10; k++)
                begin
                    pow10 = pow10 * 32'd10;
                end
                n.value = pow10 + 32'($urandom_range(0, 2)) - 32'd1;
            end
            7:          n.value = $urandom() >> (4 * $urandom_range(1, 7));
            8:          n.value = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
            default:    n.value = $urandom() >> $urandom_range(0, 31);
        endcase
        return n;
    endfunction

    task automatic queue_number(input number_t n);
        numbers_to_send.push_back(n);
        items_queued++;
    endtask

    // Sender and receiver. Both act on the falling edge, so the converter sees
    // stable inputs at every rising edge. A number stays on the channel until
    // it has been taken, and valid gets at most one assignment per edge.
    always @(negedge clk)
    begin
        if (rst_n && (!number_ch.valid || number_taken))
        begin
            if (numbers_to_send.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                outgoing = numbers_to_send.pop_front();
                number_ch.valid        <= 1'b1;
                number_ch.cmd          <= outgoing.cmd;
                number_ch.value        <= outgoing.value;
                number_ch.hex_width    <= outgoing.hex_width;
                number_ch.add_line_end <= outgoing.add_line_end;
            end
            else
            begin
                number_ch.valid <= 1'b0;
            end
        end
        if (rst_n)
        begin
            chars_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Monitor. Handshakes are sampled at the rising edge: an accepted number
    // feeds the predictor, an accepted character is checked against the oldest
    // expected one.
    always @(posedge clk)
    begin
        number_taken <= rst_n && number_ch.valid && number_ch.ready;
        if (rst_n && number_ch.valid && number_ch.ready)
        begin
            predict_chars(make_number(number_ch.cmd, number_ch.value,
                                      number_ch.hex_width, number_ch.add_line_end));
            items_accepted++;
        end
        if (rst_n && chars_ch.valid && chars_ch.ready)
        begin
            if (expected_chars.size() == 0)
            begin
                report_mismatch($sformatf("char %h last %b with none expected",
                                          chars_ch.char_out, chars_ch.last));
            end
            else if (chars_ch.char_out !== expected_chars[0].ch
                     || chars_ch.last !== expected_chars[0].last)
            begin
                report_mismatch($sformatf("char %h last %b, expected char %h last %b",
                                          chars_ch.char_out, chars_ch.last,
                                          expected_chars[0].ch, expected_chars[0].last));
                void'(expected_chars.pop_front());
            end
            else
            begin
                void'(expected_chars.pop_front());
            end
        end
    end

    // Watchdog: a hung converter or a lost handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Main sequence: reset, directed numbers, then three random phases with
    // different idling on the two sides, then the drain and the verdict.
    initial
    begin
        rst_n                  = 1'b0;
        number_ch.valid        = 1'b0;
        number_ch.cmd          = CMD_DEC;
        number_ch.value        = 32'd0;
        number_ch.hex_width    = HW_2;
        number_ch.add_line_end = 1'b0;
        chars_ch.ready         = 1'b0;
        number_taken           = 1'b0;
        items_queued           = 0;
        items_accepted         = 0;
        mismatch_count         = 0;
        cycle_count            = 0;
        send_idle_pct          = 18;
        recv_stall_pct         = 47;

        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // Decimal: zero, single digits, the step to two digits, the largest
        // value, and values around the ten-digit boundary. The hex width field
        // must not matter here.
        queue_number(make_number(CMD_DEC, 32'd0,          HW_2,       1'b0));
        queue_number(make_number(CMD_DEC, 32'd0,          HW_4,       1'b1));
        queue_number(make_number(CMD_DEC, 32'd1,          HW_2,       1'b0));
        queue_number(make_number(CMD_DEC, 32'd9,          HEX_W8,     1'b0));
        queue_number(make_number(CMD_DEC, 32'd10,         HW_2,       1'b1));
        queue_number(make_number(CMD_DEC, 32'hFFFF_FFFF,  HEX_UNUSED, 1'b1));
        queue_number(make_number(CMD_DEC, 32'd1000000000, HW_2,       1'b0));
        queue_number(make_number(CMD_DEC, 32'd999999999,  HW_4,       1'b1));
        // Hex, two nibbles: zero, full, higher nibbles ignored, leading zero.
        queue_number(make_number(CMD_HEX, 32'd0,          HW_2,       1'b0));
        queue_number(make_number(CMD_HEX, 32'h0000_00FF,  HW_2,       1'b1));
        queue_number(make_number(CMD_HEX, 32'h1234_5600,  HW_2,       1'b0));
        queue_number(make_number(CMD_HEX, 32'h0000_000A,  HW_2,       1'b0));
        // Hex, four nibbles.
        queue_number(make_number(CMD_HEX, 32'h0000_FFFF,  HW_4,       1'b0));
        queue_number(make_number(CMD_HEX, 32'hABCD_0010,  HW_4,       1'b1));
        queue_number(make_number(CMD_HEX, 32'd0,          HW_4,       1'b1));
        // Hex, eight nibbles.
        queue_number(make_number(CMD_HEX, 32'hFFFF_FFFF,  HEX_W8,     1'b1));
        queue_number(make_number(CMD_HEX, 32'h1234_5678,  HEX_W8,     1'b0));
        queue_number(make_number(CMD_HEX, 32'h0000_000F,  HEX_W8,     1'b0));
        queue_number(make_number(CMD_HEX, 32'h8000_0000,  HEX_W8,     1'b1));
        // The unused width code acts as eight nibbles.
        queue_number(make_number(CMD_HEX, 32'hFFFF_FFFF,  HEX_UNUSED, 1'b0));
        queue_number(make_number(CMD_HEX, 32'h00C0_FFEE,  HEX_UNUSED, 1'b1));
        queue_number(make_number(CMD_HEX, 32'd0,          HEX_UNUSED, 1'b0));

        for (int i = 0; i < 116; i++)
        begin
            queue_number(random_number());
        end
        while (items_accepted != items_queued)
        begin
            @(posedge clk);
        end

        // The sender now stalls often and the receiver rarely.
        send_idle_pct  = 47;
        recv_stall_pct = 18;
        for (int i = 0; i < 116; i++)
        begin
            queue_number(random_number());
        end
        while (items_accepted != items_queued)
        begin
            @(posedge clk);
        end

        // Back-to-back traffic with no idling on either side.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < 116; i++)
        begin
            queue_number(random_number());
        end
        while (items_accepted != items_queued)
        begin
            @(posedge clk);
        end

        while (expected_chars.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
